@@ sv/bb3_pkg.sv @@
// Shared types, constants and the reciprocal table for the 3x3 box blur.
package bb3_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CFG_W       = 11;
   localparam int CH_W        = 8;
   localparam int PIX_W       = 3 * CH_W;
   localparam int SUM_W       = 12;
   localparam int NUM_W       = SUM_W + 1;
   localparam int CNT_W       = 4;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W      = NUM_W + RECIP_W;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       sum;
      logic       mul;
      logic [1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic [3:0] slot_valid;
   } status_type;

   // ceil(2^18 / (2n)); exact floor for numerators below 8192
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd1:    m = 18'd131072;
         4'd2:    m = 18'd65536;
         4'd3:    m = 18'd43691;
         4'd4:    m = 18'd32768;
         4'd5:    m = 18'd26215;
         4'd6:    m = 18'd21846;
         4'd7:    m = 18'd18725;
         4'd8:    m = 18'd16384;
         4'd9:    m = 18'd14564;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ sv/bb3_dpath.sv @@
// Datapath: line stores, window, counters, masked sums and reciprocal multiply.
module bb3_dpath #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic [bb3_pkg::CFG_W-1:0]   cfg_width,
   input  logic [bb3_pkg::CFG_W-1:0]   cfg_height,
   input  logic [bb3_pkg::CH_W-1:0]    red_in,
   input  logic [bb3_pkg::CH_W-1:0]    green_in,
   input  logic [bb3_pkg::CH_W-1:0]    blue_in,
   input  bb3_pkg::cmd_type            cmd,
   output bb3_pkg::status_type         status,
   output logic [bb3_pkg::CH_W-1:0]    red_out,
   output logic [bb3_pkg::CH_W-1:0]    green_out,
   output logic [bb3_pkg::CH_W-1:0]    blue_out,
   output logic                        end_of_frame
);

   localparam int CIW = $clog2(MAX_WIDTH);
   localparam int RIW = $clog2(MAX_HEIGHT);

   logic [bb3_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [bb3_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];

   logic [bb3_pkg::PIX_W-1:0] up_rd_ff, mid_rd_ff, px_ff;
   logic [bb3_pkg::PIX_W-1:0] win_ff [9];

   logic [CIW-1:0] col_ff, col_in, cur_c_ff;
   logic [RIW-1:0] row_ff, row_in, cur_r_ff;
   logic [CIW-1:0] w_last;
   logic [RIW-1:0] h_last;

   logic [bb3_pkg::SUM_W-1:0]  sum_ff [3];
   logic [bb3_pkg::SUM_W-1:0]  sum_in [3];
   logic [bb3_pkg::CNT_W-1:0]  n_ff, n_in;
   logic                       eof_ff, eof_mul_ff;
   logic [bb3_pkg::PROD_W-1:0] prod_ff [3];
   logic [8:0]                 mask;
   logic [2:0]                 row_ok, col_ok;

   // effective frame size: zero reads as one, oversize saturates
   always_comb begin
      logic [31:0] wext, hext;
      wext = {{(32-bb3_pkg::CFG_W){1'b0}}, cfg_width};
      hext = {{(32-bb3_pkg::CFG_W){1'b0}}, cfg_height};
      if (wext == 32'd0) begin
         w_last = '0;
      end else if (wext > 32'(MAX_WIDTH)) begin
         w_last = CIW'(MAX_WIDTH - 1);
      end else begin
         w_last = CIW'(wext - 32'd1);
      end
      if (hext == 32'd0) begin
         h_last = '0;
      end else if (hext > 32'(MAX_HEIGHT)) begin
         h_last = RIW'(MAX_HEIGHT - 1);
      end else begin
         h_last = RIW'(hext - 32'd1);
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_ff >= w_last) begin
         col_in = '0;
         row_in = (row_ff >= h_last) ? '0 : row_ff + RIW'(1);
      end else begin
         col_in = col_ff + CIW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         up_rd_ff  <= older_mem[col_ff];
         mid_rd_ff <= newer_mem[col_ff];
         px_ff     <= {red_in, green_in, blue_in};
         cur_c_ff  <= col_ff;
         cur_r_ff  <= row_ff;
      end
      if (cmd.load) begin
         older_mem[cur_c_ff] <= mid_rd_ff;
         newer_mem[cur_c_ff] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i*3]   <= win_ff[i*3+1];
            win_ff[i*3+1] <= win_ff[i*3+2];
         end
         win_ff[2] <= up_rd_ff;
         win_ff[5] <= mid_rd_ff;
         win_ff[8] <= px_ff;
      end
   end

   // slot: bit 1 = right-edge pass, bit 0 = bottom row of the window
   assign status.slot_valid[0] = (cur_c_ff != '0) && (cur_r_ff != '0);
   assign status.slot_valid[1] = (cur_c_ff != '0) && (cur_r_ff == h_last);
   assign status.slot_valid[2] = (cur_c_ff == w_last) && (cur_r_ff != '0);
   assign status.slot_valid[3] = (cur_c_ff == w_last) && (cur_r_ff == h_last);

   always_comb begin
      row_ok[0] = (cur_r_ff > RIW'(1)) && !cmd.slot[0];
      row_ok[1] = (cur_r_ff != '0);
      row_ok[2] = 1'b1;
      col_ok[0] = (cur_c_ff > CIW'(1)) && !cmd.slot[1];
      col_ok[1] = (cur_c_ff != '0);
      col_ok[2] = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mask[i*3+j] = row_ok[i] && col_ok[j];
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int k = 0; k < 9; k++) begin
            if (mask[k]) begin
               sum_in[ch] = sum_in[ch] +
                  bb3_pkg::SUM_W'(win_ff[k][(2-ch)*bb3_pkg::CH_W +: bb3_pkg::CH_W]);
            end
         end
      end
      n_in = bb3_pkg::CNT_W'($countones(mask));
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int ch = 0; ch < 3; ch++) begin
            sum_ff[ch] <= sum_in[ch];
         end
         n_ff   <= n_in;
         eof_ff <= (cmd.slot == 2'd3);
      end
      if (cmd.mul) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod_ff[ch] <=
               bb3_pkg::PROD_W'({sum_ff[ch], 1'b0} + bb3_pkg::NUM_W'(n_ff)) *
               bb3_pkg::PROD_W'(bb3_pkg::recip(n_ff));
         end
         eof_mul_ff <= eof_ff;
      end
   end

   assign red_out      = prod_ff[0][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
   assign green_out    = prod_ff[1][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
   assign blue_out     = prod_ff[2][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
   assign end_of_frame = eof_mul_ff;

endmodule

@@ sv/bb3_ctrl.sv @@
// Controller: sequences load, per-result sum, multiply and output handshake.
module bb3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SCAN;
            slot_in  = 2'd0;
         end
         ST_SCAN: begin
            if (status.slot_valid[slot_ff]) begin
               state_in = ST_SUM;
            end else if (slot_ff == 2'd3) begin
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + 2'd1;
            end
         end
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) begin
               if (slot_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
                  slot_in  = slot_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   assign cmd.accept = accept;
   assign cmd.load   = (state_ff == ST_LOAD);
   assign cmd.sum    = (state_ff == ST_SUM);
   assign cmd.mul    = (state_ff == ST_MUL);
   assign cmd.slot   = slot_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOAD)
      else $error("accepted item not loaded");

   a_out_valid_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> status.slot_valid[slot_ff])
      else $error("result shown for an empty slot");

   a_last_slot_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !rsp_stall && slot_ff == 2'd3 |=> state_ff == ST_IDLE)
      else $error("no return to idle after last slot");

endmodule

@@ sv/box_blur_3x3_edge_clipped.sv @@
// 3x3 box blur over a raster RGB stream, window clipped at the frame edges.
// Each accepted pixel is loaded (accept with line store read, then window
// shift), then scanned over its four result slots; each result it releases
// goes through masked sum, reciprocal multiply and output, plus any output
// stall. One pixel is in flight at a time: the next waits until the last
// one's results are all out. Results trail their inputs by one column and
// one row; the bottom row comes out with the last input row. Register writes
// (width at 0x0, height at 0x4) restart the frame and must be made while idle.
module box_blur_3x3_edge_clipped #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [bb3_pkg::CH_W-1:0]  req_red_in,
   input  logic [bb3_pkg::CH_W-1:0]  req_green_in,
   input  logic [bb3_pkg::CH_W-1:0]  req_blue_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [bb3_pkg::CH_W-1:0]  rsp_red_out,
   output logic [bb3_pkg::CH_W-1:0]  rsp_green_out,
   output logic [bb3_pkg::CH_W-1:0]  rsp_blue_out,
   output logic                      rsp_end_of_frame,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [bb3_pkg::CFG_W-1:0] width_ff, height_ff;
   logic                      cfg_wr;
   bb3_pkg::cmd_type          cmd;
   bb3_pkg::status_type       status;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bb3_pkg::WIDTH_RESET;
         height_ff <= bb3_pkg::HEIGHT_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == bb3_pkg::REG_WIDTH) begin
            width_ff <= pwdata[bb3_pkg::CFG_W-1:0];
         end else begin
            height_ff <= pwdata[bb3_pkg::CFG_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == bb3_pkg::REG_HEIGHT) ?
                   {{(32-bb3_pkg::CFG_W){1'b0}}, height_ff} :
                   {{(32-bb3_pkg::CFG_W){1'b0}}, width_ff};

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bb3_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .restart      (cfg_wr),
      .cfg_width    (width_ff),
      .cfg_height   (height_ff),
      .red_in       (req_red_in),
      .green_in     (req_green_in),
      .blue_in      (req_blue_in),
      .cmd          (cmd),
      .status       (status),
      .red_out      (rsp_red_out),
      .green_out    (rsp_green_out),
      .blue_out     (rsp_blue_out),
      .end_of_frame (rsp_end_of_frame)
   );

endmodule

@@ dv/box_blur_3x3_edge_clipped_test.sv @@
// Self-checking testbench for the clipped 3x3 box blur: directed and random frames.
`timescale 1ns / 100ps

module box_blur_3x3_edge_clipped_test;

   localparam int STORE_DEPTH = bb3_pkg::DEF_MAX_WIDTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;
   localparam logic [2:0] ADDR_WIDTH  = {bb3_pkg::REG_WIDTH, 2'b00};
   localparam logic [2:0] ADDR_HEIGHT = {bb3_pkg::REG_HEIGHT, 2'b00};

   typedef struct {
      logic [bb3_pkg::CH_W-1:0] red;
      logic [bb3_pkg::CH_W-1:0] green;
      logic [bb3_pkg::CH_W-1:0] blue;
      logic                     eof;
   } blur_pixel_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [bb3_pkg::CH_W-1:0] req_red_in, req_green_in, req_blue_in;
   logic rsp_valid, rsp_stall;
   logic [bb3_pkg::CH_W-1:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic rsp_end_of_frame;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   box_blur_3x3_edge_clipped DUT (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // blur predictor state
   logic [bb3_pkg::PIX_W-1:0] older_row [STORE_DEPTH];
   logic [bb3_pkg::PIX_W-1:0] newer_row [STORE_DEPTH];
   logic [bb3_pkg::PIX_W-1:0] window [9];
   int                        col_pos, row_pos;
   logic [bb3_pkg::CFG_W-1:0] cfg_width, cfg_height;

   logic [bb3_pkg::PIX_W-1:0] pixel_queue [$];
   blur_pixel_type            blurred_queue [$];
   int  errors;
   int  cycles;
   bit  quiet;
   int  feed_gap, drain_gap;

   function automatic int clip_size(logic [bb3_pkg::CFG_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   task automatic blur_at(int y, int x, int r, int c, int w, int h, logic eof);
      int sr, sg, sb, n, fy, fx;
      blur_pixel_type p;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            fy = r - 2 + i;
            fx = c - 2 + j;
            if (fy < 0 || fy >= h || fx < 0 || fx >= w) continue;
            if (fy < y - 1 || fy > y + 1 || fx < x - 1 || fx > x + 1) continue;
            sr += window[i*3+j][23:16];
            sg += window[i*3+j][15:8];
            sb += window[i*3+j][7:0];
            n++;
         end
      end
      if (n == 0) begin
         p.red = '0; p.green = '0; p.blue = '0;
      end else begin
         p.red   = bb3_pkg::CH_W'((2*sr + n) / (2*n));
         p.green = bb3_pkg::CH_W'((2*sg + n) / (2*n));
         p.blue  = bb3_pkg::CH_W'((2*sb + n) / (2*n));
      end
      p.eof = eof;
      blurred_queue.push_back(p);
   endtask

   task automatic take_pixel(logic [bb3_pkg::PIX_W-1:0] px);
      int w, h, c, r, k, idx;
      logic [bb3_pkg::PIX_W-1:0] up, mid;
      w = clip_size(cfg_width, bb3_pkg::DEF_MAX_WIDTH);
      h = clip_size(cfg_height, bb3_pkg::DEF_MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      idx = col_pos % STORE_DEPTH;
      up  = older_row[idx];
      mid = newer_row[idx];
      older_row[idx] = mid;
      newer_row[idx] = px;
      for (int i = 0; i < 3; i++) begin
         window[i*3]   = window[i*3+1];
         window[i*3+1] = window[i*3+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = px;
      // left neighbor column completes first, then the last column at row end
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 0) begin
            if (c < 1) continue;
            k = c - 1;
         end else begin
            if (c != w - 1) continue;
            k = w - 1;
         end
         if (r >= 1) blur_at(r - 1, k, r, c, w, h, 1'b0);
         if (r == h - 1) blur_at(r, k, r, c, w, h, k == w - 1);
      end
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         feed_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) take_pixel({req_red_in, req_green_in, req_blue_in});
         if (!(req_valid && req_stall)) begin
            if (feed_gap > 0) begin
               feed_gap  <= feed_gap - 1;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               {req_red_in, req_green_in, req_blue_in} <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) feed_gap <= $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      blur_pixel_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         drain_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blurred_queue.size() == 0) begin
               $error("unexpected item: red %0d green %0d blue %0d eof %0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out, rsp_end_of_frame);
               errors++;
            end else begin
               e = blurred_queue.pop_front();
               if (rsp_red_out !== e.red) begin
                  $error("red_out: expected %0d, got %0d", e.red, rsp_red_out);
                  errors++;
               end
               if (rsp_green_out !== e.green) begin
                  $error("green_out: expected %0d, got %0d", e.green, rsp_green_out);
                  errors++;
               end
               if (rsp_blue_out !== e.blue) begin
                  $error("blue_out: expected %0d, got %0d", e.blue, rsp_blue_out);
                  errors++;
               end
               if (rsp_end_of_frame !== e.eof) begin
                  $error("end_of_frame: expected %0d, got %0d", e.eof, rsp_end_of_frame);
                  errors++;
               end
            end
         end
         if (drain_gap > 0) begin
            drain_gap <= drain_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            drain_gap <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_WIDTH) cfg_width = data[bb3_pkg::CFG_W-1:0];
      else cfg_height = data[bb3_pkg::CFG_W-1:0];
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic set_frame(int w, int h);
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_valid || blurred_queue.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_random(int n);
      repeat (n) pixel_queue.push_back(bb3_pkg::PIX_W'($urandom));
   endtask

   initial begin
      int w, h, n, sent;
      errors = 0; cycles = 0; quiet = 0;
      col_pos = 0; row_pos = 0;
      cfg_width = bb3_pkg::WIDTH_RESET; cfg_height = bb3_pkg::HEIGHT_RESET;
      foreach (window[i]) window[i] = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_valid = 0; req_red_in = '0; req_green_in = '0; req_blue_in = '0;
      rsp_stall = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset-size frame: first row only, nothing comes out
      push_random(5);
      wait_drained();
      // 3x3 checkerboard of extremes: corners, edges and center
      set_frame(3, 3);
      for (int i = 0; i < 9; i++) pixel_queue.push_back(i % 2 ? 24'hFFFFFF : 24'h000000);
      wait_drained();
      for (int i = 0; i < 9; i++) pixel_queue.push_back(i % 2 ? 24'h00FF00 : 24'hFF00FF);
      wait_drained();
      // single pixel frame, then a single column
      set_frame(1, 1);
      pixel_queue.push_back(24'hFF80FF);
      wait_drained();
      set_frame(1, 3);
      push_random(3);
      wait_drained();
      // zero sizes act as one
      set_frame(0, 0);
      push_random(2);
      wait_drained();
      // oversize width saturates; partial single-row frame
      set_frame(2047, 1);
      push_random(10);
      wait_drained();
      set_frame(2, 2047);
      push_random(6);
      wait_drained();

      sent = 0;
      while (sent < 420) begin
         if (sent > 350) quiet = 1;
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 8);
         if ($urandom_range(0, 3) == 0) csr_write(ADDR_HEIGHT, h);
         else set_frame(w, h);
         w = clip_size(cfg_width, bb3_pkg::DEF_MAX_WIDTH);
         h = clip_size(cfg_height, bb3_pkg::DEF_MAX_HEIGHT);
         n = w * h;
         if (n > 1 && $urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
         else if ($urandom_range(0, 4) == 0) n = 2 * n;
         push_random(n);
         sent += n;
         wait_drained();
      end

      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
